// ===== design/dfcp_pkg.sv =====
// dfcp_pkg: shared constants, codes and controller/datapath interface types
// for the fr-fcfs dram command picker; no dependencies
package dfcp_pkg;

    localparam int QUEUE_DEPTH    = 64;
    localparam int RANK_COUNT     = 2;
    localparam int BANK_COUNT     = 8;
    localparam int MASK_WIDTH     = 64;
    localparam int NUM_FLAT_BANKS = 16;
    localparam int SCAN_BANKS     = (RANK_COUNT * BANK_COUNT > NUM_FLAT_BANKS) ?
                                    NUM_FLAT_BANKS : RANK_COUNT * BANK_COUNT;
    localparam int ENTRY_SLOTS    = 128;

    localparam logic [7:0] HIT_SAT            = 8'd255;
    localparam logic [7:0] HIT_CAP_RESET      = 8'd4;
    localparam logic [6:0] HIGH_WMARK_RESET   = 7'd40;
    localparam logic [6:0] LOW_WMARK_RESET    = 7'd20;

    typedef enum logic [1:0] {
        CFG_HIT_CAP    = 2'd0,
        CFG_HIGH_WMARK = 2'd1,
        CFG_LOW_WMARK  = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        ACT_NONE      = 2'd0,
        ACT_READ      = 2'd1,
        ACT_WRITE     = 2'd2,
        ACT_PRECHARGE = 2'd3
    } action_t;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_FETCH,
        ST_COMMIT
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic dispatch;
        logic fetch;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic op_tick;
        logic out_free;
    } dp_status_t;

endpackage

// ===== design/dram_frfcfs_command_picker.sv =====
// dram_frfcfs_command_picker: top level joining controller and datapath
// depends on dfcp_pkg, dfcp_ctrl, dfcp_datapath
//
// usage:
// - input channel (s_*): one transaction is either a bank load for one entry
//   slot (operation 0, no result) or a scheduling tick (operation 1, one result)
// - result channel (m_*): action, entry index, hit and auto-precharge flags,
//   target bank and drain state after the tick
// - config channel (cfg_*): ready only while the picker waits for a transaction;
//   index 0 hit cap, 1 high watermark, 2 low watermark, other indexes ignored
// - a load captures the slot, then writes its bank into the table before the next accept
// - a tick runs in order: capture, drain decision and 64-entry priority pick,
//   bank table read, counter update into the output register
// - the output register frees the input side: the next transaction is taken
//   while a result waits; a stalled receiver holds a tick only at its last step
// - reset clears drain mode, all hit counters and the output valid, and loads
//   the register defaults; both ready outputs stay low during reset; the bank
//   table holds no reset value
module dram_frfcfs_command_picker
    import dfcp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [7:0]            cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_operation,
    input  logic [6:0]            s_slot_index,
    input  logic [3:0]            s_slot_bank,
    input  logic [MASK_WIDTH-1:0] s_read_ready,
    input  logic [MASK_WIDTH-1:0] s_read_column,
    input  logic [MASK_WIDTH-1:0] s_write_ready,
    input  logic [MASK_WIDTH-1:0] s_write_column,
    input  logic [6:0]            s_read_count,
    input  logic [6:0]            s_write_count,
    input  logic [15:0]           s_autoprecharge_ok,
    input  logic [15:0]           s_precharge_ok,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_action,
    output logic [5:0]            m_entry_index,
    output logic                  m_column_hit,
    output logic                  m_auto_precharge,
    output logic [3:0]            m_target_bank,
    output logic                  m_draining
);

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       cfg_write;

    assign cfg_ready = s_ready;
    assign cfg_write = cfg_valid && cfg_ready;

    dfcp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    dfcp_datapath u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .status             (status),
        .cfg_valid          (cfg_write),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_operation        (s_operation),
        .s_slot_index       (s_slot_index),
        .s_slot_bank        (s_slot_bank),
        .s_read_ready       (s_read_ready),
        .s_read_column      (s_read_column),
        .s_write_ready      (s_write_ready),
        .s_write_column     (s_write_column),
        .s_read_count       (s_read_count),
        .s_write_count      (s_write_count),
        .s_autoprecharge_ok (s_autoprecharge_ok),
        .s_precharge_ok     (s_precharge_ok),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_action           (m_action),
        .m_entry_index      (m_entry_index),
        .m_column_hit       (m_column_hit),
        .m_auto_precharge   (m_auto_precharge),
        .m_target_bank      (m_target_bank),
        .m_draining         (m_draining)
    );

endmodule

// ===== design/dfcp_ctrl.sv =====
// dfcp_ctrl: sequencing state machine of the command picker
// depends on dfcp_pkg; drives dfcp_datapath through dp_cmd_t
module dfcp_ctrl
    import dfcp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = aresetn;
                if (s_valid && aresetn) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                cmd.dispatch = 1'b1;
                state_next   = status.op_tick ? ST_FETCH : ST_IDLE;
            end
            ST_FETCH: begin
                cmd.fetch  = 1'b1;
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (status.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/dfcp_datapath.sv =====
// dfcp_datapath: input capture, bank table, drain hysteresis, oldest-first pick,
// per-bank hit counters and output register; depends on dfcp_pkg
module dfcp_datapath
    import dfcp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    input  logic                  cfg_valid,
    input  logic [1:0]            cfg_index,
    input  logic [7:0]            cfg_data,
    input  logic                  s_operation,
    input  logic [6:0]            s_slot_index,
    input  logic [3:0]            s_slot_bank,
    input  logic [MASK_WIDTH-1:0] s_read_ready,
    input  logic [MASK_WIDTH-1:0] s_read_column,
    input  logic [MASK_WIDTH-1:0] s_write_ready,
    input  logic [MASK_WIDTH-1:0] s_write_column,
    input  logic [6:0]            s_read_count,
    input  logic [6:0]            s_write_count,
    input  logic [15:0]           s_autoprecharge_ok,
    input  logic [15:0]           s_precharge_ok,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_action,
    output logic [5:0]            m_entry_index,
    output logic                  m_column_hit,
    output logic                  m_auto_precharge,
    output logic [3:0]            m_target_bank,
    output logic                  m_draining
);

    function automatic logic [6:0] first_set(input logic [MASK_WIDTH-1:0] m);
        logic [6:0] r;
        r = '0;
        for (int i = MASK_WIDTH - 1; i >= 0; i--) begin
            if (m[i]) begin
                r = {1'b1, 6'(i)};
            end
        end
        return r;
    endfunction

    function automatic logic [MASK_WIDTH-1:0] occupancy(input logic [6:0] count);
        logic [MASK_WIDTH-1:0] r;
        for (int i = 0; i < MASK_WIDTH; i++) begin
            r[i] = (i < QUEUE_DEPTH) && (7'(i) < count);
        end
        return r;
    endfunction

    // configuration
    logic [7:0] hit_cap_reg;
    logic [6:0] high_wmark_reg;
    logic [6:0] low_wmark_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_cap_reg    <= HIT_CAP_RESET;
            high_wmark_reg <= HIGH_WMARK_RESET;
            low_wmark_reg  <= LOW_WMARK_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_HIT_CAP:    hit_cap_reg    <= cfg_data;
                CFG_HIGH_WMARK: high_wmark_reg <= cfg_data[6:0];
                CFG_LOW_WMARK:  low_wmark_reg  <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // captured transaction
    logic                  op_reg;
    logic [6:0]            slot_index_reg;
    logic [3:0]            slot_bank_reg;
    logic [MASK_WIDTH-1:0] rd_ready_reg, rd_column_reg, wr_ready_reg, wr_column_reg;
    logic [6:0]            rd_count_reg, wr_count_reg;
    logic [15:0]           ap_ok_reg, pre_ok_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg         <= s_operation;
            slot_index_reg <= s_slot_index;
            slot_bank_reg  <= s_slot_bank;
            rd_ready_reg   <= s_read_ready;
            rd_column_reg  <= s_read_column;
            wr_ready_reg   <= s_write_ready;
            wr_column_reg  <= s_write_column;
            rd_count_reg   <= s_read_count;
            wr_count_reg   <= s_write_count;
            ap_ok_reg      <= s_autoprecharge_ok;
            pre_ok_reg     <= s_precharge_ok;
        end
    end

    // drain decision and oldest-first pick
    logic                  drain_reg, drain_next;
    logic [MASK_WIDTH-1:0] sel_ready, sel_column;
    logic [6:0]            hit_pick, any_pick;
    logic                  found_reg, hit_reg;
    logic [5:0]            pos_reg;

    always_comb begin
        drain_next = drain_reg && (wr_count_reg > low_wmark_reg);
        if (wr_count_reg > high_wmark_reg) begin
            drain_next = 1'b1;
        end else if (rd_count_reg == 7'd0) begin
            drain_next = 1'b1;
        end
        if (drain_next) begin
            sel_ready  = wr_ready_reg & occupancy(wr_count_reg);
            sel_column = wr_column_reg;
        end else begin
            sel_ready  = rd_ready_reg & occupancy(rd_count_reg);
            sel_column = rd_column_reg;
        end
        hit_pick = first_set(sel_ready & sel_column);
        any_pick = first_set(sel_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drain_reg <= 1'b0;
        end else if (cmd.dispatch && op_reg == OP_TICK) begin
            drain_reg <= drain_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.dispatch) begin
            found_reg <= any_pick[6];
            hit_reg   <= hit_pick[6];
            pos_reg   <= hit_pick[6] ? hit_pick[5:0] : any_pick[5:0];
        end
    end

    // entry bank table
    logic [3:0] entry_bank_mem [ENTRY_SLOTS];
    logic [3:0] bank_rd_reg;

    always_ff @(posedge aclk) begin
        if (cmd.dispatch && op_reg == OP_LOAD) begin
            entry_bank_mem[slot_index_reg] <= slot_bank_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.fetch) begin
            bank_rd_reg <= entry_bank_mem[{drain_reg, pos_reg}];
        end
    end

    // hit counters and result
    logic [7:0] hit_cnt_reg [NUM_FLAT_BANKS];
    logic [7:0] cnt_cur, cnt_inc;
    logic       autop;
    logic       pre_found;
    logic [3:0] pre_bank;
    logic [1:0] action_next;
    logic [3:0] bank_next;

    always_comb begin
        cnt_cur   = hit_cnt_reg[bank_rd_reg];
        cnt_inc   = (cnt_cur == HIT_SAT) ? HIT_SAT : cnt_cur + 8'd1;
        autop     = found_reg && hit_reg && (cnt_inc >= hit_cap_reg) && ap_ok_reg[bank_rd_reg];
        pre_found = 1'b0;
        pre_bank  = '0;
        for (int b = SCAN_BANKS - 1; b >= 0; b--) begin
            if (hit_cnt_reg[b] >= hit_cap_reg && pre_ok_reg[b]) begin
                pre_found = 1'b1;
                pre_bank  = 4'(b);
            end
        end
        if (found_reg) begin
            action_next = drain_reg ? ACT_WRITE : ACT_READ;
            bank_next   = bank_rd_reg;
        end else if (pre_found) begin
            action_next = ACT_PRECHARGE;
            bank_next   = pre_bank;
        end else begin
            action_next = ACT_NONE;
            bank_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int b = 0; b < NUM_FLAT_BANKS; b++) begin
                hit_cnt_reg[b] <= '0;
            end
        end else if (cmd.commit) begin
            if (found_reg) begin
                hit_cnt_reg[bank_rd_reg] <= (hit_reg && !autop) ? cnt_inc : 8'd0;
            end else if (pre_found) begin
                hit_cnt_reg[pre_bank] <= 8'd0;
            end
        end
    end

    // output register
    logic m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_action         <= action_next;
            m_entry_index    <= found_reg ? pos_reg : 6'd0;
            m_column_hit     <= found_reg && hit_reg;
            m_auto_precharge <= autop;
            m_target_bank    <= bank_next;
            m_draining       <= drain_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign status.op_tick  = op_reg;
    assign status.out_free = !m_valid_reg || m_ready;

endmodule

// ===== design/dfcp_checker.sv =====
// dfcp_checker: port-level assertions for the command picker, bound to the top
// depends on dfcp_pkg and dram_frfcfs_command_picker
module dfcp_checker
    import dfcp_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_action,
    input logic [5:0] m_entry_index,
    input logic       m_column_hit,
    input logic       m_auto_precharge,
    input logic [3:0] m_target_bank
);

    // result held while stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_action) && $stable(m_target_bank))
        else $error("result changed while stalled");

    // idle result carries no bank or entry
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_action == ACT_NONE |-> m_target_bank == 4'd0 && m_entry_index == 6'd0)
        else $error("idle result with payload");

    // flags only on issued entries
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_action == ACT_NONE || m_action == ACT_PRECHARGE)
            |-> !m_column_hit && !m_auto_precharge && m_entry_index == 6'd0)
        else $error("flags without issued entry");

    // auto-precharge only rides a row hit
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_auto_precharge |-> m_column_hit)
        else $error("auto-precharge without column hit");

    // no result right after a transaction is taken from idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> !m_valid)
        else $error("result too early");

endmodule

bind dram_frfcfs_command_picker dfcp_checker u_dfcp_checker (.*);
